// ===== hw/rtl/rwb_pkg.sv =====
// Shared types, constants and helpers for the reservoir water balance block.
package rwb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int EXP_FRAC   = 12;
    localparam int EXP_INT    = 4;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int SQRT_STEPS = 17;

    localparam logic [16:0] ONE_FX = 17'h10000;
    localparam logic [33:0] SQRT_BIT_INIT = 34'h1_0000_0000;
    localparam logic signed [51:0] SMAX48 = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [51:0] SMIN48 = -52'sh0_8000_0000_0000;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_TIN,
        ST_SUM,
        ST_CHK,
        ST_DIV,
        ST_PINT_ACC,
        ST_PINT_SQ,
        ST_SQRT,
        ST_PFRAC,
        ST_FACTOR,
        ST_EA,
        ST_EVLO,
        ST_EVHI,
        ST_CLAMP,
        ST_NET,
        ST_ADJ,
        ST_SPILL,
        ST_RESULT,
        ST_OUT
    } state_t;

    // saturate a signed value into the 48-bit signed range
    function automatic logic [47:0] sat_s48(input logic signed [51:0] v);
        logic signed [51:0] t;
        begin
            t = v;
            if (t > SMAX48)
                t = SMAX48;
            if (t < SMIN48)
                t = SMIN48;
            return t[47:0];
        end
    endfunction

endpackage

// ===== hw/rtl/rwb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rwb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/reservoir_water_balance_step_top.sv =====
// Top level of the per-cell reservoir water balance update.
//
// Input channel (in_valid/in_ready): one item names a cell and carries
// inflow, precipitation, potential evaporation, area and capacity. Output
// channel (out_valid/out_ready): one result item per input item, with
// outflow, spill, evaporation, total inflow and release.
// cfg_write_en/cfg_write_data write the reduction exponent (Q4.12, reset 1.0);
// write it only while the block is idle.
// After reset the block sweeps the volume store to zero, one cell a cycle,
// with in_ready low.
// Each item is worked by one shared 32x32 multiplier plus a bit-serial
// divider and square root under a sequencer; the work is dominated by the
// twelve 17-step square roots of the fractional exponent, which, with the
// division, are skipped when the store is over capacity.
// in_ready is high only when idle, so one item at a time. The result stays
// in its register while out_ready is low; no new item is taken until the
// result goes out.
module reservoir_water_balance_step_top #(
    parameter int CELL_COUNT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  cell_index,
    input  logic [31:0] pot_evap,
    input  logic [31:0] precip,
    input  logic [47:0] upstream_inflow,
    input  logic [31:0] surface_area,
    input  logic [47:0] capacity_volume,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [47:0] outflow,
    output logic [47:0] spill,
    output logic signed [47:0] evaporated,
    output logic [47:0] total_inflow,
    output logic signed [47:0] release_res
);

    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    rwb_pkg::state_t state_reg, state_next;

    // control
    logic [AW-1:0] clr_reg;
    logic [4:0]    step_reg;
    logic [3:0]    k_reg;
    logic [15:0]   exp_reg;

    // captured item
    logic [AW-1:0] addr_reg;
    logic          cell_ok_reg;
    logic [31:0]   pet_reg, prc_reg, area_reg;
    logic [47:0]   inflow_reg, cap_reg;

    // datapath
    logic [47:0] s0_reg, pa_reg, tin_reg, ea_reg, evap_reg;
    logic [48:0] s_reg, rem_reg, evlo_reg, evc_reg, s2_reg;
    logic [16:0] q_reg, acc_reg, p_reg, sv_reg, factor_reg;
    logic [32:0] sq_x_reg;
    logic [33:0] sq_res_reg, sq_bit_reg;
    logic signed [50:0] of_reg;
    logic [49:0] s3_reg, spill_reg;

    logic [47:0] out_of_reg, out_spill_reg, out_ev_reg, out_tin_reg, out_rel_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic [AW+9:0] cell_wide;
    logic          cell_ok;
    logic          over_cap;
    logic          div_last, sqrt_last;
    logic [48:0]   div_trial;
    logic          div_ge;
    logic [16:0]   q_new;
    logic [33:0]   sq_trial, sq_res_new;
    logic          sq_ge;
    logic          int_bit, frac_bit;
    logic [48:0]   tin_sum;
    logic [64:0]   ev_full;
    logic signed [50:0] ss;
    logic [49:0]   snew;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [47:0]   ram_wdata, ram_rdata;
    logic signed [51:0] rel_sum;

    assign cell_wide = {{AW{1'b0}}, cell_index};
    assign cell_ok   = {22'd0, cell_index} < 32'(CELL_COUNT);

    assign over_cap  = (cap_reg == 48'd0) || (s_reg > {1'b0, cap_reg});
    assign div_last  = step_reg == 5'(rwb_pkg::DIV_STEPS - 1);
    assign sqrt_last = step_reg == 5'(rwb_pkg::SQRT_STEPS - 1);
    assign int_bit   = exp_reg[4'(rwb_pkg::EXP_FRAC) + k_reg];
    assign frac_bit  = exp_reg[4'(rwb_pkg::EXP_FRAC) - k_reg];

    // long division step
    assign div_trial = (step_reg == 5'd0) ? rem_reg : {rem_reg[47:0], 1'b0};
    assign div_ge    = div_trial >= {1'b0, cap_reg};
    assign q_new     = {q_reg[15:0], div_ge};

    // square root step
    assign sq_trial   = sq_res_reg + sq_bit_reg;
    assign sq_ge      = {1'b0, sq_x_reg} >= sq_trial;
    assign sq_res_new = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

    assign tin_sum = {1'b0, inflow_reg} + {1'b0, pa_reg};
    assign ev_full = {mul_p[32:0], 32'd0} + {16'd0, evlo_reg};
    assign ss      = $signed({2'b00, s2_reg}) - of_reg;
    assign snew    = (s3_reg > {2'b00, cap_reg}) ? {2'b00, cap_reg} : s3_reg;
    assign rel_sum = 52'(of_reg) + $signed({2'b00, spill_reg});

    always_comb
    begin
        case (state_reg)
            rwb_pkg::ST_LOAD:
            begin
                mul_a = prc_reg;
                mul_b = area_reg;
            end
            rwb_pkg::ST_PINT_ACC:
            begin
                mul_a = {15'd0, acc_reg};
                mul_b = {15'd0, p_reg};
            end
            rwb_pkg::ST_PINT_SQ:
            begin
                mul_a = {15'd0, p_reg};
                mul_b = {15'd0, p_reg};
            end
            rwb_pkg::ST_PFRAC:
            begin
                mul_a = {15'd0, acc_reg};
                mul_b = {15'd0, sv_reg};
            end
            rwb_pkg::ST_EA:
            begin
                mul_a = pet_reg;
                mul_b = area_reg;
            end
            rwb_pkg::ST_EVLO:
            begin
                mul_a = ea_reg[31:0];
                mul_b = {15'd0, factor_reg};
            end
            rwb_pkg::ST_EVHI:
            begin
                mul_a = {16'd0, ea_reg[47:32]};
                mul_b = {15'd0, factor_reg};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rwb_pkg::ST_CLEAR:
                if (clr_reg == AW'(CELL_COUNT - 1))
                    state_next = rwb_pkg::ST_IDLE;
            rwb_pkg::ST_IDLE:
                if (in_valid)
                    state_next = rwb_pkg::ST_LOAD;
            rwb_pkg::ST_LOAD:     state_next = rwb_pkg::ST_TIN;
            rwb_pkg::ST_TIN:      state_next = rwb_pkg::ST_SUM;
            rwb_pkg::ST_SUM:      state_next = rwb_pkg::ST_CHK;
            rwb_pkg::ST_CHK:
                state_next = over_cap ? rwb_pkg::ST_EA : rwb_pkg::ST_DIV;
            rwb_pkg::ST_DIV:
                if (div_last)
                    state_next = rwb_pkg::ST_PINT_ACC;
            rwb_pkg::ST_PINT_ACC: state_next = rwb_pkg::ST_PINT_SQ;
            rwb_pkg::ST_PINT_SQ:
                state_next = (k_reg == 4'(rwb_pkg::EXP_INT - 1)) ?
                             rwb_pkg::ST_SQRT : rwb_pkg::ST_PINT_ACC;
            rwb_pkg::ST_SQRT:
                if (sqrt_last)
                    state_next = rwb_pkg::ST_PFRAC;
            rwb_pkg::ST_PFRAC:
                state_next = (k_reg == 4'(rwb_pkg::EXP_FRAC)) ?
                             rwb_pkg::ST_FACTOR : rwb_pkg::ST_SQRT;
            rwb_pkg::ST_FACTOR:   state_next = rwb_pkg::ST_EA;
            rwb_pkg::ST_EA:       state_next = rwb_pkg::ST_EVLO;
            rwb_pkg::ST_EVLO:     state_next = rwb_pkg::ST_EVHI;
            rwb_pkg::ST_EVHI:     state_next = rwb_pkg::ST_CLAMP;
            rwb_pkg::ST_CLAMP:    state_next = rwb_pkg::ST_NET;
            rwb_pkg::ST_NET:      state_next = rwb_pkg::ST_ADJ;
            rwb_pkg::ST_ADJ:      state_next = rwb_pkg::ST_SPILL;
            rwb_pkg::ST_SPILL:    state_next = rwb_pkg::ST_RESULT;
            rwb_pkg::ST_RESULT:   state_next = rwb_pkg::ST_OUT;
            rwb_pkg::ST_OUT:
                if (out_ready)
                    state_next = rwb_pkg::ST_IDLE;
            default:              state_next = rwb_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory port control
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = snew[47:0];
        ram_raddr = cell_wide[AW-1:0];
        unique case (state_reg)
            rwb_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 48'd0;
            end
            rwb_pkg::ST_IDLE:  in_ready  = 1'b1;
            rwb_pkg::ST_SPILL: ram_we    = cell_ok_reg;
            rwb_pkg::ST_OUT:   out_valid = 1'b1;
            default:           ram_we    = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwb_pkg::ST_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
            k_reg     <= '0;
            exp_reg   <= 16'd4096;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
                exp_reg <= cfg_write_data;
            case (state_reg)
                rwb_pkg::ST_CLEAR: clr_reg <= clr_reg + AW'(1);
                rwb_pkg::ST_CHK:
                begin
                    step_reg <= '0;
                    k_reg    <= '0;
                end
                rwb_pkg::ST_DIV:   step_reg <= div_last ? 5'd0 : step_reg + 5'd1;
                rwb_pkg::ST_SQRT:  step_reg <= sqrt_last ? 5'd0 : step_reg + 5'd1;
                rwb_pkg::ST_PINT_SQ:
                    k_reg <= (k_reg == 4'(rwb_pkg::EXP_INT - 1)) ? 4'd1 : k_reg + 4'd1;
                rwb_pkg::ST_PFRAC: k_reg <= k_reg + 4'd1;
                default:           k_reg <= k_reg;
            endcase
        end
    end

    // payload datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rwb_pkg::ST_IDLE:
                if (in_valid)
                begin
                    addr_reg    <= cell_wide[AW-1:0];
                    cell_ok_reg <= cell_ok;
                    pet_reg     <= pot_evap;
                    prc_reg     <= precip;
                    inflow_reg  <= upstream_inflow;
                    area_reg    <= surface_area;
                    cap_reg     <= capacity_volume;
                end
            rwb_pkg::ST_LOAD:
            begin
                s0_reg <= cell_ok_reg ? ram_rdata : 48'd0;
                pa_reg <= mul_p[63:16];
            end
            rwb_pkg::ST_TIN:
                tin_reg <= tin_sum[48] ? {48{1'b1}} : tin_sum[47:0];
            rwb_pkg::ST_SUM:
                s_reg <= {1'b0, s0_reg} + {1'b0, tin_reg};
            rwb_pkg::ST_CHK:
            begin
                rem_reg    <= {1'b0, cap_reg - s_reg[47:0]};
                q_reg      <= '0;
                acc_reg    <= rwb_pkg::ONE_FX;
                factor_reg <= rwb_pkg::ONE_FX;
            end
            rwb_pkg::ST_DIV:
            begin
                rem_reg <= div_ge ? div_trial - {1'b0, cap_reg} : div_trial;
                q_reg   <= q_new;
                if (div_last)
                begin
                    p_reg  <= q_new;
                    sv_reg <= q_new;
                end
            end
            rwb_pkg::ST_PINT_ACC:
                if (int_bit)
                    acc_reg <= mul_p[32:16];
            rwb_pkg::ST_PINT_SQ:
            begin
                p_reg      <= mul_p[32:16];
                sq_x_reg   <= {sv_reg, 16'd0};
                sq_res_reg <= '0;
                sq_bit_reg <= rwb_pkg::SQRT_BIT_INIT;
            end
            rwb_pkg::ST_SQRT:
            begin
                if (sq_ge)
                    sq_x_reg <= sq_x_reg - sq_trial[32:0];
                sq_res_reg <= sq_res_new;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (sqrt_last)
                    sv_reg <= sq_res_new[16:0];
            end
            rwb_pkg::ST_PFRAC:
            begin
                if (frac_bit)
                    acc_reg <= mul_p[32:16];
                sq_x_reg   <= {sv_reg, 16'd0};
                sq_res_reg <= '0;
                sq_bit_reg <= rwb_pkg::SQRT_BIT_INIT;
            end
            rwb_pkg::ST_FACTOR: factor_reg <= rwb_pkg::ONE_FX - acc_reg;
            rwb_pkg::ST_EA:     ea_reg     <= mul_p[63:16];
            rwb_pkg::ST_EVLO:   evlo_reg   <= mul_p[48:0];
            rwb_pkg::ST_EVHI:   evap_reg   <= ev_full[63:16];
            rwb_pkg::ST_CLAMP:
                evc_reg <= ({1'b0, evap_reg} > s_reg) ? s_reg : {1'b0, evap_reg};
            rwb_pkg::ST_NET:
            begin
                s2_reg <= s_reg - evc_reg;
                of_reg <= $signed({3'b000, tin_reg}) - $signed({2'b00, evc_reg});
            end
            rwb_pkg::ST_ADJ:
                if (ss < 0)
                begin
                    of_reg <= $signed({2'b00, s2_reg});
                    s3_reg <= '0;
                end
                else
                    s3_reg <= ss[49:0];
            rwb_pkg::ST_SPILL:
                spill_reg <= (s3_reg > {2'b00, cap_reg}) ? s3_reg - {2'b00, cap_reg} : '0;
            rwb_pkg::ST_RESULT:
            begin
                out_of_reg    <= rwb_pkg::sat_s48(52'(of_reg));
                out_spill_reg <= spill_reg[47:0];
                out_ev_reg    <= rwb_pkg::sat_s48($signed({3'b000, evc_reg}));
                out_tin_reg   <= tin_reg;
                out_rel_reg   <= rwb_pkg::sat_s48(rel_sum);
            end
            default:
                out_tin_reg <= out_tin_reg;
        endcase
    end

    rwb_ram #(
        .WIDTH (48),
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign outflow      = out_of_reg;
    assign spill        = out_spill_reg;
    assign evaporated   = out_ev_reg;
    assign total_inflow = out_tin_reg;
    assign release_res  = out_rel_reg;

endmodule

// ===== hw/rtl/rwb_checker.sv =====
// Port-level checks for the reservoir water balance block, bound to the top.
module rwb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [47:0] outflow,
    input logic [47:0] spill,
    input logic [47:0] evaporated,
    input logic [47:0] total_inflow,
    input logic [47:0] release_res
);

    // one item in flight: never ready while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready high while result pending");

    // an accepted item cannot produce its result in the next cycle
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid && !in_ready)
        else $error("result or ready right after accept");

    // at most one result per item
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
        else $error("result repeated");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(outflow) && $stable(spill)
            && $stable(evaporated) && $stable(total_inflow) && $stable(release_res))
        else $error("stalled result changed");

endmodule

bind reservoir_water_balance_step_top rwb_checker u_rwb_checker (.*);
